// File: sv/cdd_pkg.sv
`timescale 1ns / 1ps
// Shared widths, order codes and the month table for the date difference block.
// No dependencies.
package cdd_pkg;

  localparam int DAY_W    = 5;
  localparam int MONTH_W  = 4;
  localparam int YEAR_W   = 14;
  localparam int SERIAL_W = 23;
  localparam int SPAN_W   = 22;
  localparam int ORDER_W  = 2;
  localparam int DBM_W    = 9;
  localparam int LEAPS_W  = 13;
  localparam int QUOT_W   = 9;
  localparam int PROD_W   = 28;

  localparam int IN_DATA_W  = 48;
  localparam int OUT_DATA_W = 32;

  localparam int YEAR_MAX_DEFAULT = 9999;

  // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for x < 43690
  localparam logic [PROD_W-1:0] RECIP_100   = PROD_W'(5243);
  localparam int                RECIP_SHIFT = 19;

  localparam logic [MONTH_W-1:0] MONTH_JAN = MONTH_W'(1);
  localparam logic [MONTH_W-1:0] MONTH_FEB = MONTH_W'(2);
  localparam logic [MONTH_W-1:0] MONTH_DEC = MONTH_W'(12);

  typedef enum logic [ORDER_W-1:0] {
    ORD_EQUAL         = 2'd0,
    ORD_FIRST_EARLIER = 2'd1,
    ORD_FIRST_LATER   = 2'd2
  } order_t;

  function automatic logic [DBM_W-1:0] days_before(input logic [MONTH_W-1:0] month);
    logic [DBM_W-1:0] res;
    case (month)
      4'd1:    res = 9'd0;
      4'd2:    res = 9'd31;
      4'd3:    res = 9'd59;
      4'd4:    res = 9'd90;
      4'd5:    res = 9'd120;
      4'd6:    res = 9'd151;
      4'd7:    res = 9'd181;
      4'd8:    res = 9'd212;
      4'd9:    res = 9'd243;
      4'd10:   res = 9'd273;
      4'd11:   res = 9'd304;
      4'd12:   res = 9'd334;
      default: res = 9'd0;
    endcase
    return res;
  endfunction

endpackage

// File: sv/cdd_serial.sv
`timescale 1ns / 1ps
// Serial day count of one date, three register stages, advanced by en.
// Depends on cdd_pkg.
module cdd_serial (
  input  logic                          clk,
  input  logic                          en,
  input  logic [cdd_pkg::DAY_W-1:0]     day_i,
  input  logic [cdd_pkg::MONTH_W-1:0]   month_i,
  input  logic [cdd_pkg::YEAR_W-1:0]    year_i,
  output logic [cdd_pkg::SERIAL_W-1:0]  serial_o
);

  localparam int PW = cdd_pkg::PROD_W;
  localparam int RS = cdd_pkg::RECIP_SHIFT;
  localparam int QW = cdd_pkg::QUOT_W;
  localparam int LW = cdd_pkg::LEAPS_W;
  localparam int SW = cdd_pkg::SERIAL_W;
  localparam int DW = cdd_pkg::DBM_W;

  // stage A: quotients and 365*y
  logic [cdd_pkg::YEAR_W-1:0]  y_r;
  logic [cdd_pkg::DAY_W-1:0]   d_r;
  logic [cdd_pkg::MONTH_W-1:0] m_r;
  logic [SW-1:0]               y365_r;
  logic [LW-1:0]               q4_r;
  logic [QW-1:0]               q100_r, q400_r, qy_r;

  logic [PW-1:0] p100_nxt, p400_nxt, py_nxt, y399;
  logic [SW-1:0] y365_nxt;
  logic [LW-1:0] q4_nxt;

  always_comb begin
    y365_nxt = SW'(year_i) * SW'(365);
    q4_nxt   = LW'((PW'(year_i) + PW'(3)) >> 2);
    p100_nxt = (PW'(year_i) + PW'(99)) * cdd_pkg::RECIP_100;
    y399     = (PW'(year_i) + PW'(399)) >> 2;
    p400_nxt = y399 * cdd_pkg::RECIP_100;
    py_nxt   = PW'(year_i) * cdd_pkg::RECIP_100;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      y_r    <= year_i;
      d_r    <= day_i;
      m_r    <= month_i;
      y365_r <= y365_nxt;
      q4_r   <= q4_nxt;
      q100_r <= p100_nxt[RS +: QW];
      q400_r <= p400_nxt[RS +: QW];
      qy_r   <= py_nxt[RS +: QW];
    end
  end

  // stage B: leap count, leap flag, month offset
  logic [SW-1:0] base_r, base_nxt;
  logic [LW-1:0] leaps_r, leaps_nxt;
  logic [DW-1:0] dbm_r, dbm_nxt;
  logic          is_leap;

  always_comb begin
    leaps_nxt = q4_r - LW'(q100_r) + LW'(q400_r);
    is_leap   = (y_r[1:0] == 2'b00) &&
                ((PW'(y_r) != PW'(qy_r) * PW'(100)) || (qy_r[1:0] == 2'b00));
    dbm_nxt   = cdd_pkg::days_before(m_r) +
                DW'(is_leap && (m_r > cdd_pkg::MONTH_FEB));
    base_nxt  = y365_r + SW'(d_r);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      base_r  <= base_nxt;
      leaps_r <= leaps_nxt;
      dbm_r   <= dbm_nxt;
    end
  end

  // stage C: final sum
  logic [SW-1:0] serial_r;

  always_ff @(posedge clk) begin
    if (en) begin
      serial_r <= base_r + SW'(leaps_r) + SW'(dbm_r);
    end
  end

  assign serial_o = serial_r;

endmodule

// File: sv/calendar_date_difference_top.sv
`timescale 1ns / 1ps
// Top level of the Gregorian date difference pipeline.
// Depends on cdd_pkg and cdd_serial.
//
//  channel | ports          | tdata fields, lowest bit up
//  --------+----------------+------------------------------------------------
//  input   | in_t*          | first_day, first_month, first_year,
//          |                | second_day, second_month, second_year
//  result  | out_t*         | day_span, order, month_error
//
// Five register stages, one transaction per cycle.
// Stages: year clamp and compare, quotients, leap terms, serial sum, span.
// A stall on out_tready freezes every stage together; nothing is dropped.
// Synchronous active-low reset clears only the valid bits.
module calendar_date_difference_top #(
  parameter int YEAR_MAX = cdd_pkg::YEAR_MAX_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  // first_day[4:0], first_month[8:5], first_year[22:9],
  // second_day[27:23], second_month[31:28], second_year[45:32], zero[47:46]
  input  logic [cdd_pkg::IN_DATA_W-1:0]   in_tdata,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  // day_span[21:0], order[23:22], month_error[24], zero[31:25]
  output logic [cdd_pkg::OUT_DATA_W-1:0]  out_tdata
);

  localparam int DW  = cdd_pkg::DAY_W;
  localparam int MW  = cdd_pkg::MONTH_W;
  localparam int YW  = cdd_pkg::YEAR_W;
  localparam int SW  = cdd_pkg::SERIAL_W;
  localparam int SPW = cdd_pkg::SPAN_W;
  localparam int CW  = YW + 3;
  localparam logic [CW-1:0] YMAX = CW'(YEAR_MAX);
  localparam int MID = 3;

  logic ce;
  assign ce        = !out_tvalid || out_tready;
  assign in_tready = ce;

  logic [DW-1:0] d1, d2;
  logic [MW-1:0] m1, m2;
  logic [YW-1:0] y1, y2, y1c, y2c;

  always_comb begin
    d1  = in_tdata[4:0];
    m1  = in_tdata[8:5];
    y1  = in_tdata[22:9];
    d2  = in_tdata[27:23];
    m2  = in_tdata[31:28];
    y2  = in_tdata[45:32];
    y1c = (CW'(y1) > YMAX) ? YMAX[YW-1:0] : y1;
    y2c = (CW'(y2) > YMAX) ? YMAX[YW-1:0] : y2;
  end

  // stage 1: clamp, compare, month check
  logic              v1_r;
  logic [DW-1:0]     d1_r, d2_r;
  logic [MW-1:0]     m1_r, m2_r;
  logic [YW-1:0]     y1_r, y2_r;
  cdd_pkg::order_t   ord1_r, ord_nxt;
  logic              bad1_r, bad_nxt;

  always_comb begin
    if ({y1c, m1, d1} == {y2c, m2, d2}) begin
      ord_nxt = cdd_pkg::ORD_EQUAL;
    end else if ({y1c, m1, d1} > {y2c, m2, d2}) begin
      ord_nxt = cdd_pkg::ORD_FIRST_LATER;
    end else begin
      ord_nxt = cdd_pkg::ORD_FIRST_EARLIER;
    end
    bad_nxt = (m1 < cdd_pkg::MONTH_JAN) || (m1 > cdd_pkg::MONTH_DEC) ||
              (m2 < cdd_pkg::MONTH_JAN) || (m2 > cdd_pkg::MONTH_DEC);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (ce) begin
      v1_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      d1_r   <= d1;
      m1_r   <= m1;
      y1_r   <= y1c;
      d2_r   <= d2;
      m2_r   <= m2;
      y2_r   <= y2c;
      ord1_r <= ord_nxt;
      bad1_r <= bad_nxt;
    end
  end

  // serial counts, three stages
  logic [SW-1:0] s1, s2;

  cdd_serial u_serial_first (
    .clk      (clk),
    .en       (ce),
    .day_i    (d1_r),
    .month_i  (m1_r),
    .year_i   (y1_r),
    .serial_o (s1)
  );

  cdd_serial u_serial_second (
    .clk      (clk),
    .en       (ce),
    .day_i    (d2_r),
    .month_i  (m2_r),
    .year_i   (y2_r),
    .serial_o (s2)
  );

  // side band alongside the serial stages
  logic            v_r   [MID];
  cdd_pkg::order_t ord_r [MID];
  logic            bad_r [MID];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MID; i++) begin
        v_r[i] <= 1'b0;
      end
    end else if (ce) begin
      v_r[0] <= v1_r;
      for (int i = 1; i < MID; i++) begin
        v_r[i] <= v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      ord_r[0] <= ord1_r;
      bad_r[0] <= bad1_r;
      for (int i = 1; i < MID; i++) begin
        ord_r[i] <= ord_r[i-1];
        bad_r[i] <= bad_r[i-1];
      end
    end
  end

  // stage 5: span and output register
  logic [SW-1:0]   diff;
  logic [SPW-1:0]  span_nxt, span_r;
  cdd_pkg::order_t ord_out_r;
  logic            err_nxt, err_r, vout_r;

  always_comb begin
    diff = (s1 > s2) ? (s1 - s2) : (s2 - s1);
    if (ord_r[MID-1] == cdd_pkg::ORD_EQUAL || bad_r[MID-1]) begin
      span_nxt = '0;
    end else if (diff[SW-1]) begin
      span_nxt = '1;
    end else begin
      span_nxt = diff[SPW-1:0];
    end
    err_nxt = bad_r[MID-1] && (ord_r[MID-1] != cdd_pkg::ORD_EQUAL);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vout_r <= 1'b0;
    end else if (ce) begin
      vout_r <= v_r[MID-1];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      span_r    <= span_nxt;
      ord_out_r <= ord_r[MID-1];
      err_r     <= err_nxt;
    end
  end

  assign out_tvalid = vout_r;
  assign out_tdata  = {7'd0, err_r, ord_out_r, span_r};

endmodule

// File: tb/sv/calendar_date_difference_top_test.sv
`timescale 1ns / 1ps
// Self-checking bench for calendar_date_difference_top: directed date pairs, then random
// ones, with stalls on both stream sides. Depends on cdd_pkg and the block's RTL.
module calendar_date_difference_top_test;

  localparam int          YEAR_CAP        = cdd_pkg::YEAR_MAX_DEFAULT;
  localparam longint      SPAN_SAT        = 4194303;
  localparam int          RANDOM_ITEMS    = 1800;
  localparam int          LONG_HOLD       = 64;
  localparam int          DRAIN_CYCLES    = 20;
  localparam int unsigned WATCHDOG_LIMIT  = 2000;

  typedef struct packed {
    logic [cdd_pkg::DAY_W-1:0]   first_day;
    logic [cdd_pkg::MONTH_W-1:0] first_month;
    logic [cdd_pkg::YEAR_W-1:0]  first_year;
    logic [cdd_pkg::DAY_W-1:0]   second_day;
    logic [cdd_pkg::MONTH_W-1:0] second_month;
    logic [cdd_pkg::YEAR_W-1:0]  second_year;
  } date_pair_t;

  typedef struct packed {
    logic [cdd_pkg::SPAN_W-1:0] day_span;
    cdd_pkg::order_t            order;
    logic                       month_error;
  } span_result_t;

  typedef struct packed {
    date_pair_t   dates;
    logic         typed;
    span_result_t golden;
  } dir_row_t;

  logic                           clk        = 1'b0;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [cdd_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [cdd_pkg::OUT_DATA_W-1:0] out_tdata;

  dir_row_t     offered_rows [$];
  span_result_t pending_spans [$];
  int unsigned  mismatch_count = 0;
  bit           calm = 1'b0;
  bit           long_hold = 1'b0;

  calendar_date_difference_top #(.YEAR_MAX(YEAR_CAP)) dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // serial day number: 365*y + leap years in [0, y) + days of earlier months + d
  function automatic longint unsigned serial_count(input logic [cdd_pkg::DAY_W-1:0] d,
                                                   input logic [cdd_pkg::MONTH_W-1:0] m,
                                                   input logic [cdd_pkg::YEAR_W-1:0] y);
    longint unsigned yy;
    longint unsigned prior_days;
    bit              leap;
    yy = 64'(y);
    leap = ((yy % 4 == 0) && (yy % 100 != 0)) || (yy % 400 == 0);
    case (m)
      4'd2:    prior_days = 31;
      4'd3:    prior_days = 59;
      4'd4:    prior_days = 90;
      4'd5:    prior_days = 120;
      4'd6:    prior_days = 151;
      4'd7:    prior_days = 181;
      4'd8:    prior_days = 212;
      4'd9:    prior_days = 243;
      4'd10:   prior_days = 273;
      4'd11:   prior_days = 304;
      4'd12:   prior_days = 334;
      default: prior_days = 0;
    endcase
    if (m > cdd_pkg::MONTH_FEB && leap) prior_days = prior_days + 1;
    return 365 * yy + (yy + 3) / 4 - (yy + 99) / 100 + (yy + 399) / 400 + prior_days + d;
  endfunction

  function automatic span_result_t day_gap(input date_pair_t p);
    logic [cdd_pkg::YEAR_W-1:0] ya;
    logic [cdd_pkg::YEAR_W-1:0] yb;
    longint unsigned            sa;
    longint unsigned            sb;
    longint unsigned            gap;
    span_result_t               r;
    ya = (p.first_year > YEAR_CAP) ? cdd_pkg::YEAR_W'(YEAR_CAP) : p.first_year;
    yb = (p.second_year > YEAR_CAP) ? cdd_pkg::YEAR_W'(YEAR_CAP) : p.second_year;
    r.day_span = '0;
    r.order = cdd_pkg::ORD_EQUAL;
    r.month_error = 1'b0;
    if (ya == yb && p.first_month == p.second_month && p.first_day == p.second_day)
      return r;
    if (ya > yb || (ya == yb && (p.first_month > p.second_month ||
        (p.first_month == p.second_month && p.first_day > p.second_day))))
      r.order = cdd_pkg::ORD_FIRST_LATER;
    else
      r.order = cdd_pkg::ORD_FIRST_EARLIER;
    if (p.first_month < cdd_pkg::MONTH_JAN || p.first_month > cdd_pkg::MONTH_DEC ||
        p.second_month < cdd_pkg::MONTH_JAN || p.second_month > cdd_pkg::MONTH_DEC) begin
      r.month_error = 1'b1;
    end else begin
      sa = serial_count(p.first_day, p.first_month, ya);
      sb = serial_count(p.second_day, p.second_month, yb);
      gap = (sa > sb) ? sa - sb : sb - sa;
      if (gap > SPAN_SAT) gap = SPAN_SAT;
      r.day_span = gap[cdd_pkg::SPAN_W-1:0];
    end
    return r;
  endfunction

  function automatic logic [cdd_pkg::DAY_W-1:0] random_day();
    if ($urandom_range(0, 7) == 0) return cdd_pkg::DAY_W'($urandom_range(0, 31));
    return cdd_pkg::DAY_W'($urandom_range(1, 28));
  endfunction

  function automatic logic [cdd_pkg::YEAR_W-1:0] random_year();
    case ($urandom_range(0, 3))
      0:       return cdd_pkg::YEAR_W'($urandom_range(0, 16383));
      1:       return cdd_pkg::YEAR_W'($urandom_range(0, YEAR_CAP));
      2:       return cdd_pkg::YEAR_W'($urandom_range(1583, 2100));
      default: return cdd_pkg::YEAR_W'($urandom_range(YEAR_CAP - 9, 16383));
    endcase
  endfunction

  function automatic date_pair_t random_pair();
    date_pair_t                  p;
    int unsigned                 pick;
    logic [cdd_pkg::MONTH_W-1:0] bad;
    pick = $urandom_range(0, 99);
    p.first_day    = random_day();
    p.first_month  = cdd_pkg::MONTH_W'($urandom_range(1, 12));
    p.first_year   = random_year();
    p.second_day   = random_day();
    p.second_month = cdd_pkg::MONTH_W'($urandom_range(1, 12));
    p.second_year  = random_year();
    if (pick < 4) begin
      // raw noise over every field
      p.first_day    = cdd_pkg::DAY_W'($urandom);
      p.first_month  = cdd_pkg::MONTH_W'($urandom);
      p.first_year   = cdd_pkg::YEAR_W'($urandom);
      p.second_day   = cdd_pkg::DAY_W'($urandom);
      p.second_month = cdd_pkg::MONTH_W'($urandom);
      p.second_year  = cdd_pkg::YEAR_W'($urandom);
    end else if (pick < 32) begin
      // neighbors: same date with one field nudged, or identical
      p.second_day   = p.first_day;
      p.second_month = p.first_month;
      p.second_year  = p.first_year;
      case ($urandom_range(0, 3))
        0:       p.second_day = cdd_pkg::DAY_W'($urandom_range(0, 31));
        1:       p.second_month = cdd_pkg::MONTH_W'($urandom_range(1, 12));
        2:       p.second_year = p.first_year ^ cdd_pkg::YEAR_W'($urandom_range(0, 3));
        default: begin
          p.first_month  = cdd_pkg::MONTH_W'($urandom_range(0, 15));
          p.second_month = p.first_month;
        end
      endcase
    end else if (pick < 42) begin
      bad = ($urandom_range(0, 3) == 0) ? cdd_pkg::MONTH_W'(0) :
                                          cdd_pkg::MONTH_W'($urandom_range(13, 15));
      if ($urandom_range(0, 1) == 0) p.first_month = bad;
      else p.second_month = bad;
    end
    return p;
  endfunction

  task automatic offer_dates(input dir_row_t row, input bit may_idle);
    if (may_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk);
    end
    offered_rows.push_back(row);
    in_tdata  <= {2'b00, row.dates.second_year, row.dates.second_month,
                  row.dates.second_day, row.dates.first_year, row.dates.first_month,
                  row.dates.first_day};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
  endtask

  // stream sink: random ready bursts, one long hold-off on request, steady ready once calm
  initial begin : sink
    int unsigned span_len;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (long_hold) begin
        out_tready <= 1'b0;
        span_len = LONG_HOLD;
        long_hold = 1'b0;
      end else if (calm) begin
        out_tready <= 1'b1;
        span_len = 1;
      end else begin
        out_tready <= ($urandom_range(0, 3) != 0);
        span_len = $urandom_range(1, 16);
      end
      repeat (span_len) @(posedge clk);
    end
  end

  always @(posedge clk) begin : scoreboard
    dir_row_t     row;
    date_pair_t   seen;
    span_result_t want;
    if (rst_n && in_tvalid && in_tready) begin
      row = offered_rows.pop_front();
      seen.first_day    = in_tdata[4:0];
      seen.first_month  = in_tdata[8:5];
      seen.first_year   = in_tdata[22:9];
      seen.second_day   = in_tdata[27:23];
      seen.second_month = in_tdata[31:28];
      seen.second_year  = in_tdata[45:32];
      pending_spans.push_back(row.typed ? row.golden : day_gap(seen));
    end
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_spans.size() == 0) begin
        $error("unexpected result transaction: tdata %h", out_tdata);
        mismatch_count++;
      end else begin
        want = pending_spans.pop_front();
        if (out_tdata[21:0] !== want.day_span) begin
          $error("day_span: expected %0d, actual %0d", want.day_span, out_tdata[21:0]);
          mismatch_count++;
        end
        if (out_tdata[23:22] !== want.order) begin
          $error("order: expected %0d, actual %0d", want.order, out_tdata[23:22]);
          mismatch_count++;
        end
        if (out_tdata[24] !== want.month_error) begin
          $error("month_error: expected %0d, actual %0d", want.month_error, out_tdata[24]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet_run;
    quiet_run = 0;
    while (quiet_run < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet_run = 0;
      else quiet_run++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin : stimulus
    dir_row_t rows [22];
    dir_row_t item;
    bit       gaps_ok;
    // dates: d1, m1, y1, d2, m2, y2 | typed | span, order, month_error
    rows = '{
      '{'{0, 0, 0, 0, 0, 0},             1'b1, '{0, cdd_pkg::ORD_EQUAL, 0}},
      '{'{31, 15, 16383, 31, 15, 16383}, 1'b1, '{0, cdd_pkg::ORD_EQUAL, 0}},
      '{'{1, 0, 2000, 1, 1, 2000},       1'b1, '{0, cdd_pkg::ORD_FIRST_EARLIER, 1}},
      '{'{1, 1, 2000, 1, 13, 2000},      1'b1, '{0, cdd_pkg::ORD_FIRST_EARLIER, 1}},
      '{'{5, 14, 9999, 5, 3, 0},         1'b1, '{0, cdd_pkg::ORD_FIRST_LATER, 1}},
      '{'{1, 1, 16383, 1, 1, 9999},      1'b1, '{0, cdd_pkg::ORD_EQUAL, 0}},
      '{'{2, 6, 12000, 2, 6, 10000},     1'b1, '{0, cdd_pkg::ORD_EQUAL, 0}},
      '{'{1, 1, 2024, 2, 1, 2024},       1'b1, '{1, cdd_pkg::ORD_FIRST_EARLIER, 0}},
      '{'{1, 3, 1900, 28, 2, 1900},      1'b1, '{1, cdd_pkg::ORD_FIRST_LATER, 0}},
      '{'{0, 1, 0, 31, 12, 9999},        1'b0, '{0, cdd_pkg::ORD_EQUAL, 0}},
      '{'{31, 12, 16383, 0, 1, 0},       1'b0, '{0, cdd_pkg::ORD_EQUAL, 0}},
      '{'{28, 2, 2000, 1, 3, 2000},      1'b1, '{2, cdd_pkg::ORD_FIRST_EARLIER, 0}},
      '{'{28, 2, 2100, 1, 3, 2100},      1'b1, '{1, cdd_pkg::ORD_FIRST_EARLIER, 0}},
      '{'{31, 2, 2001, 1, 3, 2001},      1'b1, '{2, cdd_pkg::ORD_FIRST_EARLIER, 0}},
      '{'{0, 3, 2000, 29, 2, 2000},      1'b1, '{0, cdd_pkg::ORD_FIRST_LATER, 0}},
      '{'{1, 1, 400, 1, 1, 0},           1'b1, '{146097, cdd_pkg::ORD_FIRST_LATER, 0}},
      '{'{1, 3, 0, 1, 2, 0},             1'b1, '{29, cdd_pkg::ORD_FIRST_LATER, 0}},
      '{'{15, 7, 1969, 20, 7, 1969},     1'b1, '{5, cdd_pkg::ORD_FIRST_EARLIER, 0}},
      '{'{10, 15, 5000, 10, 15, 6000},   1'b1, '{0, cdd_pkg::ORD_FIRST_EARLIER, 1}},
      '{'{31, 4, 9999, 1, 5, 9998},      1'b0, '{0, cdd_pkg::ORD_EQUAL, 0}},
      '{'{17, 8, 10922, 10, 5, 5461},    1'b0, '{0, cdd_pkg::ORD_EQUAL, 0}},
      '{'{1, 12, 9999, 31, 12, 9998},    1'b0, '{0, cdd_pkg::ORD_EQUAL, 0}}
    };
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (rows[i]) offer_dates(rows[i], 1'b1);

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      if (n == 600) long_hold = 1'b1;
      if (n == 1200) begin
        // let the pipeline run dry before carrying on
        in_tvalid <= 1'b0;
        do @(posedge clk); while (pending_spans.size() != 0 || offered_rows.size() != 0);
      end
      if (n == 1600) calm = 1'b1;
      gaps_ok = !calm && !(n >= 600 && n < 700);
      item.dates  = random_pair();
      item.typed  = 1'b0;
      item.golden = '0;
      offer_dates(item, gaps_ok);
    end
    in_tvalid <= 1'b0;

    while (pending_spans.size() != 0 || offered_rows.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_spans.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
